/* design/cln_pkg.sv */
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types and constants for the character LCD nibble writer.
// ----------------------------------------------------------------------------
package cln_pkg;

  // request command codes
  localparam logic [1:0] CMD_INSTR  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PULSE      = 3'd0;
  localparam logic [2:0] REG_SETTLE     = 3'd1;
  localparam logic [2:0] REG_BYTE_GAP   = 3'd2;
  localparam logic [2:0] REG_CLEAR_WAIT = 3'd3;
  localparam logic [2:0] REG_CLEAR_CODE = 3'd4;
  localparam logic [2:0] REG_ADDR_OP    = 3'd5;

  // configuration reset values
  localparam logic [7:0]  PULSE_RST      = 8'd1;
  localparam logic [9:0]  SETTLE_RST     = 10'd50;
  localparam logic [15:0] BYTE_GAP_RST   = 16'd50;
  localparam logic [15:0] CLEAR_WAIT_RST = 16'd2000;
  localparam logic [7:0]  CLEAR_CODE_RST = 8'd1;
  localparam logic [7:0]  ADDR_OP_RST    = 8'd128;

  // segment order within one byte
  localparam logic [1:0] SEG_HI_ON  = 2'd0;
  localparam logic [1:0] SEG_HI_OFF = 2'd1;
  localparam logic [1:0] SEG_LO_ON  = 2'd2;
  localparam logic [1:0] SEG_LO_OFF = 2'd3;

  // last valid cursor row
  localparam logic [2:0] ROW_MAX = 3'd3;

  // one decoded byte waiting to go out as segments
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       clear;
  } job_t;

  // DDRAM start address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      2'd3: b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/cln_decode.sv */
// ----------------------------------------------------------------------------
// cln_decode
// Turns one request into the byte to send, its RS level and clear flag.
// ----------------------------------------------------------------------------
module cln_decode (
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  input  logic [2:0]  row,
  input  logic [6:0]  column,
  input  logic [7:0]  clear_code,
  input  logic [7:0]  address_opcode,
  output logic        produces,
  output cln_pkg::job_t job
);
  import cln_pkg::*;

  logic [7:0] addr;

  assign addr = address_opcode | ({1'b0, column} + row_base(row[1:0]));

  always_comb begin
    produces = 1'b0;
    job.rs   = 1'b0;
    job.data = byte_value;
    unique case (command)
      CMD_INSTR: begin
        produces = 1'b1;
      end
      CMD_DATA: begin
        produces = 1'b1;
        job.rs   = 1'b1;
      end
      CMD_CURSOR: begin
        produces = (row <= ROW_MAX);
        job.data = addr;
      end
      default: begin
        produces = 1'b0;
      end
    endcase
    // only instructions get the long clear wait
    job.clear = !job.rs && (job.data == clear_code);
  end

endmodule

/* design/char_lcd_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit HD44780-style LCD write sequencer: request in, timed pin words out.
// ----------------------------------------------------------------------------
// Each accepted request (instruction byte, data byte or cursor move) yields
// four output words: high nibble with E high for pulse_us, high nibble with
// E low for settle_us, then the same for the low nibble; the fourth word also
// carries the byte gap, or the clear wait for the clear instruction, and has
// last set. Cursor moves with row 4..7 and command code 3 produce nothing.
// Throughput: one output word per cycle while the sink does not stall, set by
// the single job register feeding the output register. A new request is
// taken in the same cycle the previous job hands over its fourth word. An
// accepted request is held in the job register, and each word then passes
// through the output register before out_valid is raised. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  input  logic [2:0]  row,
  input  logic [6:0]  column,
  // pin word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        register_select,
  output logic        enable,
  output logic [3:0]  nibble,
  output logic [16:0] hold_us,
  output logic        last
);
  import cln_pkg::*;

  // configuration registers
  logic [7:0]  pulse_us;
  logic [9:0]  settle_us;
  logic [15:0] byte_gap_us;
  logic [15:0] clear_wait_us;
  logic [7:0]  clear_code;
  logic [7:0]  address_opcode;

  // decoded request
  logic dec_produces;
  job_t dec_job;

  // job register: byte being split into words, plus word counter
  logic       job_valid;
  job_t       job;
  logic [1:0] seg;

  logic        out_load;
  logic        job_done;
  logic        in_take;
  logic [15:0] tail;
  logic [16:0] hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_us       <= PULSE_RST;
      settle_us      <= SETTLE_RST;
      byte_gap_us    <= BYTE_GAP_RST;
      clear_wait_us  <= CLEAR_WAIT_RST;
      clear_code     <= CLEAR_CODE_RST;
      address_opcode <= ADDR_OP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSE:      pulse_us       <= cfg_data[7:0];
        REG_SETTLE:     settle_us      <= cfg_data[9:0];
        REG_BYTE_GAP:   byte_gap_us    <= cfg_data;
        REG_CLEAR_WAIT: clear_wait_us  <= cfg_data;
        REG_CLEAR_CODE: clear_code     <= cfg_data[7:0];
        REG_ADDR_OP:    address_opcode <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  cln_decode u_decode (
    .command        (command),
    .byte_value     (byte_value),
    .row            (row),
    .column         (column),
    .clear_code     (clear_code),
    .address_opcode (address_opcode),
    .produces       (dec_produces),
    .job            (dec_job)
  );

  // a word moves into the output register when it is empty or draining
  assign out_load = job_valid && (!out_valid || !out_stall);
  assign job_done = out_load && (seg == SEG_LO_OFF);
  // job register frees up as its final word leaves
  assign in_stall = job_valid && !job_done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      seg       <= SEG_HI_ON;
    end else begin
      if (out_load) begin
        seg <= seg + 2'd1;
      end
      if (job_done) begin
        job_valid <= 1'b0;
      end
      // requests that yield nothing are simply dropped here
      if (in_take) begin
        job_valid <= dec_produces;
        seg       <= SEG_HI_ON;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      job <= dec_job;
    end
  end

  assign tail = job.clear ? clear_wait_us : byte_gap_us;

  always_comb begin
    unique case (seg)
      SEG_HI_ON:  hold_next = {9'd0, pulse_us};
      SEG_HI_OFF: hold_next = {7'd0, settle_us};
      SEG_LO_ON:  hold_next = {9'd0, pulse_us};
      SEG_LO_OFF: hold_next = {7'd0, settle_us} + {1'b0, tail};
      default:    hold_next = {9'd0, pulse_us};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      register_select <= job.rs;
      enable          <= (seg == SEG_HI_ON) || (seg == SEG_LO_ON);
      nibble          <= (seg == SEG_LO_ON || seg == SEG_LO_OFF) ?
                         job.data[3:0] : job.data[7:4];
      hold_us         <= hold_next;
      last            <= (seg == SEG_LO_OFF);
    end
  end

endmodule
